@@ hdl/pav_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pav_pkg
// shared widths, constants and types of the polygon area and box accumulator
// ----------------------------------------------------------------------------
package pav_pkg;

    localparam int COORD_BITS  = 24;
    localparam int PROD_BITS   = 2 * COORD_BITS;
    localparam int SUM_BITS    = 64;
    localparam int TOTAL_BITS  = 60;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic [SUM_BITS-1:0]          t_sum;
    typedef logic [TOTAL_BITS-1:0]        t_total;

    // classified vertex word passed from front to back
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord prev_x;
        t_coord prev_y;
        logic   new_set;
        logic   is_first;
        logic   closed;
    } t_entry;

    typedef struct packed {
        t_coord min_x;
        t_coord max_x;
        t_coord min_y;
        t_coord max_y;
    } t_box;

    // per-word flags and box travelling down the back pipeline
    typedef struct packed {
        logic new_set;
        logic is_first;
        logic closed;
        t_box box;
    } t_info;

endpackage

@@ hdl/pav_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pav_in_if
// vertex channel: valid, ready and one vertex word
// ----------------------------------------------------------------------------
interface pav_in_if;
    logic           valid;
    logic           ready;
    pav_pkg::t_coord x;
    pav_pkg::t_coord y;
    logic           new_set;

    modport source (output valid, output x, output y, output new_set, input ready);
    modport sink   (input valid, input x, input y, input new_set, output ready);
endinterface

@@ hdl/pav_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pav_out_if
// result channel: valid, ready, running area total, box and closure flag
// ----------------------------------------------------------------------------
interface pav_out_if;
    logic           valid;
    logic           ready;
    pav_pkg::t_total area_x2_total;
    pav_pkg::t_coord min_x;
    pav_pkg::t_coord max_x;
    pav_pkg::t_coord min_y;
    pav_pkg::t_coord max_y;
    logic           polygon_closed;

    modport source (output valid, output area_x2_total, output min_x, output max_x,
                    output min_y, output max_y, output polygon_closed, input ready);
    modport sink   (input valid, input area_x2_total, input min_x, input max_x,
                    input min_y, input max_y, input polygon_closed, output ready);
endinterface

@@ hdl/pav_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pav_front
// accepts vertices, tracks first and previous vertex, flags opens and closures
// ----------------------------------------------------------------------------
module pav_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pav_in_if.sink           i_in,
    output logic             o_push,
    output pav_pkg::t_entry  o_entry,
    input  logic             i_queue_ready
);

    logic            r_expect_first;
    pav_pkg::t_coord r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic            w_is_first, w_closed;

    assign i_in.ready = i_queue_ready;
    assign o_push     = i_in.valid & i_queue_ready;

    // classify the incoming word
    always_comb begin
        w_is_first = i_in.new_set | r_expect_first;
        w_closed   = !w_is_first && (i_in.x == r_first_x) && (i_in.y == r_first_y);
        o_entry.x        = i_in.x;
        o_entry.y        = i_in.y;
        o_entry.prev_x   = r_prev_x;
        o_entry.prev_y   = r_prev_y;
        o_entry.new_set  = i_in.new_set;
        o_entry.is_first = w_is_first;
        o_entry.closed   = w_closed;
    end

    // polygon tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_first <= 1'b1;
        end else if (o_push) begin
            if (w_is_first) begin
                r_expect_first <= 1'b0;
            end else if (w_closed) begin
                r_expect_first <= 1'b1;
            end
        end
    end

    // vertex latches, always written before they are read
    always_ff @(posedge i_clk) begin
        if (o_push) begin
            if (w_is_first) begin
                r_first_x <= i_in.x;
                r_first_y <= i_in.y;
                r_prev_x  <= i_in.x;
                r_prev_y  <= i_in.y;
            end else if (!w_closed) begin
                r_prev_x  <= i_in.x;
                r_prev_y  <= i_in.y;
            end
        end
    end

endmodule

@@ hdl/pav_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pav_queue
// small fifo of classified words between front and back
// ----------------------------------------------------------------------------
module pav_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pav_pkg::t_entry  i_entry,
    output logic             o_ready,
    output logic             o_valid,
    output pav_pkg::t_entry  o_entry,
    input  logic             i_pop
);

    pav_pkg::t_entry               r_mem [pav_pkg::QUEUE_DEPTH];
    logic [pav_pkg::QUEUE_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [pav_pkg::QUEUE_AW:0]    r_count;
    logic                          w_pop;

    assign o_ready = (r_count != (pav_pkg::QUEUE_AW+1)'(pav_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign w_pop   = i_pop & o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

@@ hdl/pav_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pav_back
// four-stage datapath: products and box, polygon sum, magnitude, total
// ----------------------------------------------------------------------------
module pav_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  pav_pkg::t_entry  i_entry,
    output logic             o_pop,
    pav_out_if.source        o_out
);

    logic            w_adv;
    logic            r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    pav_pkg::t_info  r_s1_info, r_s2_info, r_s3_info, r_s4_info;
    pav_pkg::t_prod  r_s1_a, r_s1_b;
    pav_pkg::t_sum   r_psum, n_psum, r_s2_sum, r_s3_mag;
    pav_pkg::t_total r_total, n_total, w_base;
    logic [pav_pkg::TOTAL_BITS:0] w_zero_pad;
    logic [pav_pkg::SUM_BITS:0]   w_add;
    pav_pkg::t_box   r_box, n_box;
    logic            r_box_valid;

    // whole pipeline moves together when the result register can take a word
    assign w_adv = !r_s4_valid || o_out.ready;
    assign o_pop = w_adv;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_box_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            if (i_valid) begin
                r_box_valid <= 1'b1;
            end
        end
    end

    // box update, seeded by the first word of a set
    always_comb begin
        if (!r_box_valid || i_entry.new_set) begin
            n_box.min_x = i_entry.x;
            n_box.max_x = i_entry.x;
            n_box.min_y = i_entry.y;
            n_box.max_y = i_entry.y;
        end else begin
            n_box = r_box;
            if ($signed(i_entry.x) < $signed(r_box.min_x)) n_box.min_x = i_entry.x;
            if ($signed(i_entry.x) > $signed(r_box.max_x)) n_box.max_x = i_entry.x;
            if ($signed(i_entry.y) < $signed(r_box.min_y)) n_box.min_y = i_entry.y;
            if ($signed(i_entry.y) > $signed(r_box.max_y)) n_box.max_y = i_entry.y;
        end
    end

    // stage 1: cross products and box
    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_box              <= n_box;
            r_s1_a             <= $signed(i_entry.prev_x) * $signed(i_entry.y);
            r_s1_b             <= $signed(i_entry.prev_y) * $signed(i_entry.x);
            r_s1_info.new_set  <= i_entry.new_set;
            r_s1_info.is_first <= i_entry.is_first;
            r_s1_info.closed   <= i_entry.closed;
            r_s1_info.box      <= n_box;
        end
    end

    // stage 2: running polygon sum, wraps at 64 bits
    always_comb begin
        if (r_s1_info.is_first) begin
            n_psum = '0;
        end else begin
            n_psum = r_psum
                   + {{(pav_pkg::SUM_BITS-pav_pkg::PROD_BITS){r_s1_a[pav_pkg::PROD_BITS-1]}},
                      r_s1_a}
                   - {{(pav_pkg::SUM_BITS-pav_pkg::PROD_BITS){r_s1_b[pav_pkg::PROD_BITS-1]}},
                      r_s1_b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum <= '0;
        end else if (w_adv && r_s1_valid) begin
            r_psum <= n_psum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_sum  <= n_psum;
            r_s2_info <= r_s1_info;
        end
    end

    // stage 3: magnitude as two's complement
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_mag  <= r_s2_sum[pav_pkg::SUM_BITS-1] ? ('0 - r_s2_sum) : r_s2_sum;
            r_s3_info <= r_s2_info;
        end
    end

    // stage 4: saturating total
    always_comb begin
        w_base     = r_s3_info.new_set ? '0 : r_total;
        w_zero_pad = {1'b0, w_base};
        w_add      = {{(pav_pkg::SUM_BITS-pav_pkg::TOTAL_BITS){1'b0}}, w_zero_pad}
                   + {1'b0, r_s3_mag};
        if (!r_s3_info.closed) begin
            n_total = w_base;
        end else if (w_add[pav_pkg::SUM_BITS:pav_pkg::TOTAL_BITS] != '0) begin
            n_total = pav_pkg::TOTAL_MAX;
        end else begin
            n_total = w_add[pav_pkg::TOTAL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (w_adv && r_s3_valid) begin
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_info <= r_s3_info;
        end
    end

    // result word
    assign o_out.valid          = r_s4_valid;
    assign o_out.area_x2_total  = r_total;
    assign o_out.min_x          = r_s4_info.box.min_x;
    assign o_out.max_x          = r_s4_info.box.max_x;
    assign o_out.min_y          = r_s4_info.box.min_y;
    assign o_out.max_y          = r_s4_info.box.max_y;
    assign o_out.polygon_closed = r_s4_info.closed;

endmodule

@@ hdl/polygon_area_bbox_accumulator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_area_bbox_accumulator_unit
// shoelace doubled-area total and bounding box over a vertex stream
// ----------------------------------------------------------------------------
// i_in carries one vertex word per handshake (x, y signed, 8 fraction bits,
// new_set). a polygon closes when a vertex repeats its first vertex; new_set
// starts a fresh set, clearing the total and the box and dropping any open
// polygon. o_out returns one word per vertex: the saturating doubled-area
// total (16 fraction bits), the box of the set so far and a closure flag.
// the front classifies each vertex and writes it into a four-word queue;
// the back runs it through products, polygon sum, magnitude and total.
// throughput: one vertex per cycle while o_out.ready stays high, set by the
// one-word-per-cycle back pipeline with its two 24x24 multipliers in the
// first stage. when o_out.ready is low the back holds, the queue fills and
// i_in.ready drops once four words wait. synchronous reset empties the queue
// and the pipeline, clears total and polygon sum, marks the box empty and
// waits for a first vertex.
// ----------------------------------------------------------------------------
module polygon_area_bbox_accumulator_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pav_in_if.sink    i_in,
    pav_out_if.source o_out
);

    logic            w_push, w_queue_ready, w_queue_valid, w_pop;
    pav_pkg::t_entry w_front_entry, w_back_entry;

    // front: accept and classify
    pav_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .o_push        (w_push),
        .o_entry       (w_front_entry),
        .i_queue_ready (w_queue_ready)
    );

    // queue between the two halves
    pav_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .o_ready (w_queue_ready),
        .o_valid (w_queue_valid),
        .o_entry (w_back_entry),
        .i_pop   (w_pop)
    );

    // back: arithmetic and result register
    pav_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_queue_valid),
        .i_entry (w_back_entry),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
